// ----- rtl/bsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants and codes for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int MAP_BITS   = 1024;
   localparam int WORD_BITS  = 32;
   localparam int NUM_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int BIT_W      = $clog2(MAP_BITS);
   localparam int OFF_W      = $clog2(WORD_BITS);
   localparam int WADDR_W    = $clog2(NUM_WORDS);
   localparam int SIZE_W     = 11;
   localparam int HINT_W     = 16;
   localparam int HINT_CNT_W = $clog2(HINT_W);

   typedef enum logic [1:0] {
      CMD_TEST    = 2'd0,
      CMD_TRY_SET = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_ALLOC   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

endpackage

// ----- rtl/bitmap_slot_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Next-fit bitmap allocator over a 32 x 32-bit word memory.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_command / req_bit_number / req_start_hint with
//   start high; the transfer happens on a clock edge where busy is low. While
//   busy is high the block ignores start.
//   Response channel: one result per command, shown for exactly one cycle
//   with rsp_valid high. The receiver cannot stall, so results are never held.
//   CSR channel: csr_bits_in_use is written on csr_valid & csr_ready; ready is
//   always high. Write it only while the block is idle.
// Steps from accept to response strobe:
//   out-of-range or size-zero commands: answered directly.
//   test / try set / clear: word read, then modify-write.
//   allocate: bit-serial hint modulo over the 16 hint bits, first word read,
//   then one word per cycle over up to 33 word visits.
//   The word-by-word scan is set by the single read port of the word memory.
// Reset: the map reads as all free (per-word valid flags are cleared), the
//   size register returns to 1024, and the block is idle.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator (
   input  logic                           clock,
   input  logic                           reset,
   // command channel
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_command,
   input  logic [bsa_pkg::BIT_W-1:0]      req_bit_number,
   input  logic [bsa_pkg::HINT_W-1:0]     req_start_hint,
   // response channel
   output logic                           rsp_valid,
   output logic                           rsp_hit,
   output logic [bsa_pkg::BIT_W-1:0]      rsp_slot_index,
   output logic [1:0]                     rsp_status,
   // csr write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bsa_pkg::SIZE_W-1:0]     csr_bits_in_use
);

   localparam int WB = bsa_pkg::WORD_BITS;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_BIT  = 5'b00010,
      S_DIV  = 5'b00100,
      S_ARD  = 5'b01000,
      S_SCAN = 5'b10000
   } state_type;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type                           state_ff, state_in;
   logic [bsa_pkg::SIZE_W-1:0]          size_cfg_ff;
   logic [bsa_pkg::NUM_WORDS-1:0]       wvalid_ff;      // word written since reset

   logic [1:0]                          cmd_ff, cmd_in;
   logic [bsa_pkg::BIT_W-1:0]           bit_ff, bit_in;
   logic [bsa_pkg::HINT_W-1:0]          hint_ff, hint_in;
   logic [bsa_pkg::SIZE_W-1:0]          rem_ff, rem_in;
   logic [bsa_pkg::HINT_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [bsa_pkg::BIT_W-1:0]           pos_ff, pos_in;      // scan start
   logic [bsa_pkg::WADDR_W-1:0]         word_ff, word_in;    // word in rd data
   logic                                pass_ff, pass_in;    // 1 after wrap

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_hit_ff, rsp_hit_in;
   logic [bsa_pkg::BIT_W-1:0]           rsp_slot_ff, rsp_slot_in;
   logic [1:0]                          rsp_status_ff, rsp_status_in;

   // word memory, one read and one write port
   logic [WB-1:0]                       mem [bsa_pkg::NUM_WORDS];
   logic [WB-1:0]                       rd_data_ff;
   logic                                rd_valid_ff;
   logic [bsa_pkg::WADDR_W-1:0]         rd_addr;
   logic                                wr_en;
   logic [bsa_pkg::WADDR_W-1:0]         wr_addr;
   logic [WB-1:0]                       wr_data;

   // ------------------------------------------------------------------
   // Derived values
   // ------------------------------------------------------------------
   logic [bsa_pkg::SIZE_W-1:0]          size;
   logic [bsa_pkg::BIT_W-1:0]           size_m1;
   logic [bsa_pkg::WADDR_W-1:0]         last_w;
   logic [bsa_pkg::OFF_W:0]             last_cnt;
   logic [WB-1:0]                       word_data;
   logic [WB-1:0]                       bit_sel;
   logic                                accept;
   logic                                req_range;
   logic [bsa_pkg::SIZE_W:0]            trial;
   logic [WB-1:0]                       scan_mask;
   logic [WB-1:0]                       free_vec;
   logic                                free_any;
   logic [bsa_pkg::OFF_W-1:0]           free_idx;
   logic [bsa_pkg::WADDR_W-1:0]         next_w;
   logic                                next_pass;

   always_comb begin
      if (size_cfg_ff > bsa_pkg::SIZE_W'(bsa_pkg::MAP_BITS)) begin
         size = bsa_pkg::SIZE_W'(bsa_pkg::MAP_BITS);
      end else begin
         size = size_cfg_ff;
      end
   end

   assign size_m1   = bsa_pkg::BIT_W'(size - bsa_pkg::SIZE_W'(1));
   assign last_w    = size_m1[bsa_pkg::BIT_W-1 -: bsa_pkg::WADDR_W];
   // bits in the last word: 1..WORD_BITS
   assign last_cnt  = (bsa_pkg::OFF_W+1)'(size_m1[bsa_pkg::OFF_W-1:0]) +
                      (bsa_pkg::OFF_W+1)'(1);

   assign word_data = rd_valid_ff ? rd_data_ff : '0;
   assign bit_sel   = WB'(1) << bit_ff[bsa_pkg::OFF_W-1:0];

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // out of range: size zero, or bit command past the size
   assign req_range = (size == '0) ||
                      ((req_command != bsa_pkg::CMD_ALLOC) &&
                       ({1'b0, req_bit_number} >= size));

   // restoring modulo step
   assign trial = {rem_ff, hint_ff[bsa_pkg::HINT_W-1]};

   // candidate mask for the word being scanned
   always_comb begin
      scan_mask = '1;
      if (word_ff == pos_ff[bsa_pkg::BIT_W-1 -: bsa_pkg::WADDR_W]) begin
         if (pass_ff) begin
            scan_mask = ~('1 << pos_ff[bsa_pkg::OFF_W-1:0]);
         end else begin
            scan_mask = '1 << pos_ff[bsa_pkg::OFF_W-1:0];
         end
      end
      if (word_ff == last_w) begin
         scan_mask = scan_mask & (WB'('1) >> ((bsa_pkg::OFF_W+1)'(WB) - last_cnt));
      end
   end

   assign free_vec = ~word_data & scan_mask;

   // lowest free bit
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int j = WB - 1; j >= 0; j--) begin
         if (free_vec[j]) begin
            free_any = 1'b1;
            free_idx = bsa_pkg::OFF_W'(j);
         end
      end
   end

   always_comb begin
      if (!pass_ff && (word_ff == last_w)) begin
         next_w    = '0;
         next_pass = 1'b1;
      end else begin
         next_w    = word_ff + bsa_pkg::WADDR_W'(1);
         next_pass = pass_ff;
      end
   end

   // ------------------------------------------------------------------
   // Control
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      bit_in        = bit_ff;
      hint_in       = hint_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      pass_in       = pass_ff;
      rsp_valid_in  = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = word_ff;
      wr_en         = 1'b0;
      wr_addr       = word_ff;
      wr_data       = word_data;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = req_bit_number[bsa_pkg::BIT_W-1 -: bsa_pkg::WADDR_W];
            if (accept) begin
               cmd_in  = req_command;
               bit_in  = req_bit_number;
               hint_in = req_start_hint;
               rem_in  = '0;
               cnt_in  = '0;
               if (req_range) begin
                  rsp_valid_in  = 1'b1;
                  rsp_hit_in    = 1'b0;
                  rsp_slot_in   = '0;
                  rsp_status_in = bsa_pkg::ST_RANGE;
               end else if (req_command == bsa_pkg::CMD_ALLOC) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_BIT;
               end
            end
         end

         S_BIT: begin
            // word for bit_ff is in the read register
            wr_addr       = bit_ff[bsa_pkg::BIT_W-1 -: bsa_pkg::WADDR_W];
            rsp_valid_in  = 1'b1;
            rsp_slot_in   = '0;
            rsp_status_in = bsa_pkg::ST_OK;
            rsp_hit_in    = 1'b0;
            case (cmd_ff)
               bsa_pkg::CMD_TEST: begin
                  rsp_hit_in = |(word_data & bit_sel);
               end
               bsa_pkg::CMD_TRY_SET: begin
                  rsp_hit_in = ~|(word_data & bit_sel);
                  wr_en      = 1'b1;
                  wr_data    = word_data | bit_sel;
               end
               default: begin
                  wr_en   = 1'b1;
                  wr_data = word_data & ~bit_sel;
               end
            endcase
            state_in = S_IDLE;
         end

         S_DIV: begin
            // one quotient bit per cycle, MSB first
            if (trial >= {1'b0, size}) begin
               rem_in = bsa_pkg::SIZE_W'(trial - {1'b0, size});
            end else begin
               rem_in = bsa_pkg::SIZE_W'(trial);
            end
            hint_in = hint_ff << 1;
            cnt_in  = cnt_ff + bsa_pkg::HINT_CNT_W'(1);
            if (cnt_ff == bsa_pkg::HINT_CNT_W'(bsa_pkg::HINT_W - 1)) begin
               state_in = S_ARD;
            end
         end

         S_ARD: begin
            pos_in   = bsa_pkg::BIT_W'(rem_ff);
            rd_addr  = rem_ff[bsa_pkg::BIT_W-1 -: bsa_pkg::WADDR_W];
            word_in  = rem_ff[bsa_pkg::BIT_W-1 -: bsa_pkg::WADDR_W];
            pass_in  = 1'b0;
            state_in = S_SCAN;
         end

         S_SCAN: begin
            rd_addr = next_w;
            if (free_any) begin
               wr_en         = 1'b1;
               wr_data       = word_data | (WB'(1) << free_idx);
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = 1'b1;
               rsp_slot_in   = {word_ff, free_idx};
               rsp_status_in = bsa_pkg::ST_OK;
               state_in      = S_IDLE;
            end else if (pass_ff &&
                         (word_ff == pos_ff[bsa_pkg::BIT_W-1 -: bsa_pkg::WADDR_W])) begin
               // wrapped back to the start word: map full
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = 1'b0;
               rsp_slot_in   = '0;
               rsp_status_in = bsa_pkg::ST_FULL;
               state_in      = S_IDLE;
            end else begin
               word_in = next_w;
               pass_in = next_pass;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Sequential
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_cfg_ff  <= bsa_pkg::SIZE_W'(1024);
         wvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            size_cfg_ff <= csr_bits_in_use;
         end
         if (wr_en) begin
            wvalid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      bit_ff        <= bit_in;
      hint_ff       <= hint_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      pass_ff       <= pass_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   // word memory: synchronous read, registered in rd_data_ff
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // per-word written flag travels with the read data; cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= wvalid_ff[rd_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ----- sim/tb_bitmap_slot_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_slot_allocator
// Self-checking bench for the next-fit bitmap allocator. A directed table of
// commands and size writes comes first, then random phases at varied map
// sizes. A local copy of the used/free map predicts the answers (directed rows
// may give one by hand), and they are checked in order against the response strobe.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator;

   localparam int QUIET_LIMIT = 1000;   // cycles with no transfer of any kind
   localparam int TAIL_CYCLES = 60;     // wait after the final drain before the verdict

   typedef struct packed {
      logic                      hit;
      logic [bsa_pkg::BIT_W-1:0] slot;
      bsa_pkg::status_type       status;
   } answer_type;

   typedef struct packed {
      bit                         is_cfg;
      logic [bsa_pkg::SIZE_W-1:0] cfg_value;
      bsa_pkg::cmd_type           cmd;
      logic [bsa_pkg::BIT_W-1:0]  bit_num;
      logic [bsa_pkg::HINT_W-1:0] hint;
      bit                         typed;     // want holds a value read off by hand
      answer_type                 want;
   } dir_row_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [1:0]                   req_command;
   logic [bsa_pkg::BIT_W-1:0]    req_bit_number;
   logic [bsa_pkg::HINT_W-1:0]   req_start_hint;
   logic                         rsp_valid;
   logic                         rsp_hit;
   logic [bsa_pkg::BIT_W-1:0]    rsp_slot_index;
   logic [1:0]                   rsp_status;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [bsa_pkg::SIZE_W-1:0]   csr_bits_in_use;

   // local copy of the map and the size register
   logic [bsa_pkg::MAP_BITS-1:0] slot_used;
   logic [bsa_pkg::SIZE_W-1:0]   map_size;

   answer_type                   answers_due[$];
   int                           fail_count = 0;
   int                           quiet_cycles = 0;

   bitmap_slot_allocator dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_bit_number  (req_bit_number),
      .req_start_hint  (req_start_hint),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_bits_in_use (csr_bits_in_use)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one command to the local map and returns its answer.
   function automatic answer_type slot_map_step(bsa_pkg::cmd_type c,
                                                logic [bsa_pkg::BIT_W-1:0] b,
                                                logic [bsa_pkg::HINT_W-1:0] h);
      int unsigned eff;
      int unsigned pos;
      int unsigned n;
      bit          found;
      answer_type  r;
      r.hit    = 1'b0;
      r.slot   = '0;
      r.status = bsa_pkg::ST_OK;
      found    = 1'b0;
      // oversize acts as full map
      eff = (map_size > bsa_pkg::MAP_BITS) ? bsa_pkg::MAP_BITS : map_size;
      if (eff == 0) begin
         r.status = bsa_pkg::ST_RANGE;
      end else if (c == bsa_pkg::CMD_ALLOC) begin
         // circular next-fit scan from hint mod size
         pos      = h % eff;
         r.status = bsa_pkg::ST_FULL;
         for (n = 0; n < eff && !found; n++) begin
            if (!slot_used[pos]) begin
               slot_used[pos] = 1'b1;
               r.hit    = 1'b1;
               r.slot   = pos[bsa_pkg::BIT_W-1:0];
               r.status = bsa_pkg::ST_OK;
               found    = 1'b1;
            end else begin
               pos = (pos + 1 >= eff) ? 0 : pos + 1;
            end
         end
      end else if (b >= eff) begin
         r.status = bsa_pkg::ST_RANGE;
      end else if (c == bsa_pkg::CMD_TEST) begin
         r.hit = slot_used[b];
      end else if (c == bsa_pkg::CMD_TRY_SET) begin
         r.hit        = !slot_used[b];
         slot_used[b] = 1'b1;
      end else begin
         slot_used[b] = 1'b0;
      end
      return r;
   endfunction

   function automatic dir_row_type cmd_row(bsa_pkg::cmd_type c, int b, int h);
      dir_row_type r;
      r         = '0;
      r.cmd     = c;
      r.bit_num = b[bsa_pkg::BIT_W-1:0];
      r.hint    = h[bsa_pkg::HINT_W-1:0];
      return r;
   endfunction

   function automatic dir_row_type fixed_row(bsa_pkg::cmd_type c, int b, int h,
                                             bit hit, int slot,
                                             bsa_pkg::status_type st);
      dir_row_type r;
      r             = cmd_row(c, b, h);
      r.typed       = 1'b1;
      r.want.hit    = hit;
      r.want.slot   = slot[bsa_pkg::BIT_W-1:0];
      r.want.status = st;
      return r;
   endfunction

   function automatic dir_row_type cfg_row(int v);
      dir_row_type r;
      r           = '0;
      r.is_cfg    = 1'b1;
      r.cfg_value = v[bsa_pkg::SIZE_W-1:0];
      return r;
   endfunction

   // One command transfer; start stays high afterwards so bursts run back to back.
   task automatic issue(bsa_pkg::cmd_type c, logic [bsa_pkg::BIT_W-1:0] b,
                        logic [bsa_pkg::HINT_W-1:0] h, bit typed, answer_type want);
      answer_type pred;
      @(negedge clock);
      start          <= 1'b1;
      req_command    <= c;
      req_bit_number <= b;
      req_start_hint <= h;
      do @(posedge clock); while (busy);
      pred = slot_map_step(c, b, h);
      answers_due.push_back(typed ? want : pred);
   endtask

   task automatic idle_gap(int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Hold off until every outstanding answer has come back.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (answers_due.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_size(logic [bsa_pkg::SIZE_W-1:0] v);
      drain();
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_bits_in_use <= v;
      do @(posedge clock); while (!csr_ready);
      map_size = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response check: in order, field by field.
   always @(posedge clock) begin : result_check
      answer_type want;
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected result hit %0d slot %0d status %0d", $time,
                     rsp_hit, rsp_slot_index, rsp_status);
            fail_count++;
         end else begin
            want = answers_due.pop_front();
            if (rsp_hit !== want.hit || rsp_slot_index !== want.slot ||
                rsp_status !== want.status) begin
               $display("%0t: exp hit %0d slot %0d st %0d, act hit %0d slot %0d st %0d",
                        $time, want.hit, want.slot, want.status,
                        rsp_hit, rsp_slot_index, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on any channel.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_bitmap_slot_allocator failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      dir_row_type                dir_table[$];
      dir_row_type                row;
      answer_type                 none;
      bsa_pkg::cmd_type           c;
      int unsigned                eff;
      int                         roll;
      int                         n_items;
      int                         burst_left;
      logic [bsa_pkg::SIZE_W-1:0] sz;
      logic [bsa_pkg::BIT_W-1:0]  b;
      logic [bsa_pkg::HINT_W-1:0] h;

      none            = '0;
      reset           = 1'b1;
      start           = 1'b0;
      req_command     = bsa_pkg::CMD_TEST;
      req_bit_number  = '0;
      req_start_hint  = '0;
      csr_valid       = 1'b0;
      csr_bits_in_use = '0;
      slot_used       = '0;
      map_size        = bsa_pkg::SIZE_W'(bsa_pkg::MAP_BITS);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // fresh map, full size
      dir_table.push_back(fixed_row(bsa_pkg::CMD_TEST,    0,    0,     0, 0,
                                    bsa_pkg::ST_OK));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_TEST,    1023, 0,     0, 0,
                                    bsa_pkg::ST_OK));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_TRY_SET, 0,    0,     1, 0,
                                    bsa_pkg::ST_OK));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_TRY_SET, 0,    0,     0, 0,
                                    bsa_pkg::ST_OK));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_TEST,    0,    0,     1, 0,
                                    bsa_pkg::ST_OK));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_CLEAR,   0,    0,     0, 0,
                                    bsa_pkg::ST_OK));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_ALLOC,   0,    0,     1, 0,
                                    bsa_pkg::ST_OK));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_ALLOC,   0,    0,     1, 1,
                                    bsa_pkg::ST_OK));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_ALLOC,   0,    65535, 1, 1023,
                                    bsa_pkg::ST_OK));
      dir_table.push_back(cmd_row(bsa_pkg::CMD_ALLOC,     0,    65535));  // wraps past the top
      dir_table.push_back(fixed_row(bsa_pkg::CMD_TRY_SET, 1023, 0,     0, 0,
                                    bsa_pkg::ST_OK));
      dir_table.push_back(cmd_row(bsa_pkg::CMD_CLEAR,     1023, 0));
      // size zero: everything out of range, nothing changes
      dir_table.push_back(cfg_row(0));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_TEST,    0,    0,     0, 0,
                                    bsa_pkg::ST_RANGE));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_ALLOC,   0,    1,     0, 0,
                                    bsa_pkg::ST_RANGE));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_CLEAR,   0,    0,     0, 0,
                                    bsa_pkg::ST_RANGE));
      // size above the map acts as the full map
      dir_table.push_back(cfg_row(2047));
      dir_table.push_back(cmd_row(bsa_pkg::CMD_TEST,      0,    0));
      dir_table.push_back(cmd_row(bsa_pkg::CMD_TEST,      1023, 0));
      // three slots, all taken
      dir_table.push_back(cfg_row(3));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_TRY_SET, 3,    0,     0, 0,
                                    bsa_pkg::ST_RANGE));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_ALLOC,   0,    1,     0, 0,
                                    bsa_pkg::ST_FULL));
      dir_table.push_back(cmd_row(bsa_pkg::CMD_CLEAR,     1,    0));
      dir_table.push_back(cmd_row(bsa_pkg::CMD_ALLOC,     0,    2));
      // single slot
      dir_table.push_back(cfg_row(1));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_ALLOC,   0,    65535, 0, 0,
                                    bsa_pkg::ST_FULL));
      dir_table.push_back(cmd_row(bsa_pkg::CMD_CLEAR,     0,    0));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_ALLOC,   0,    65535, 1, 0,
                                    bsa_pkg::ST_OK));
      dir_table.push_back(fixed_row(bsa_pkg::CMD_TRY_SET, 1023, 0,     0, 0,
                                    bsa_pkg::ST_RANGE));

      foreach (dir_table[i]) begin
         row = dir_table[i];
         if (row.is_cfg)
            write_size(row.cfg_value);
         else
            issue(row.cmd, row.bit_num, row.hint, row.typed, row.want);
      end

      // --- random phases, each at its own map size ---
      burst_left = 0;
      for (int p = 0; p < 12; p++) begin
         case (p)
            0:       sz = 11'd8;
            1:       sz = 11'd1024;
            2:       sz = 11'd40;
            3:       sz = 11'd0;
            4:       sz = 11'd2047;
            5:       sz = 11'd1;
            6:       sz = 11'd31;
            7:       sz = bsa_pkg::SIZE_W'($urandom_range(1, 2047));
            8:       sz = 11'd33;
            9:       sz = bsa_pkg::SIZE_W'($urandom_range(2, 64));
            10:      sz = 11'd96;
            default: sz = bsa_pkg::SIZE_W'($urandom_range(900, 1024));
         endcase
         write_size(sz);
         n_items = (sz == 0) ? 40 : 165;
         eff = (map_size > bsa_pkg::MAP_BITS) ? bsa_pkg::MAP_BITS : map_size;

         for (int k = 0; k < n_items; k++) begin
            // sender bursts with random gaps; a quarter of bursts follow on directly
            if (burst_left == 0) begin
               if ($urandom_range(0, 3) != 0)
                  idle_gap($urandom_range(1, 12));
               burst_left = $urandom_range(1, 30);
            end
            burst_left--;
            // now and then wait for the pipeline to empty
            if ($urandom_range(0, 49) == 0)
               drain();

            roll = $urandom_range(0, 99);
            if (roll < 40)
               c = bsa_pkg::CMD_ALLOC;
            else if (roll < 60)
               c = bsa_pkg::CMD_TRY_SET;
            else if (roll < 80)
               c = bsa_pkg::CMD_CLEAR;
            else
               c = bsa_pkg::CMD_TEST;
            // mostly in-range bit numbers, some anywhere
            if (eff != 0 && $urandom_range(0, 99) < 85)
               b = bsa_pkg::BIT_W'($urandom_range(0, eff - 1));
            else
               b = bsa_pkg::BIT_W'($urandom_range(0, bsa_pkg::MAP_BITS - 1));
            if ($urandom_range(0, 99) < 70)
               h = bsa_pkg::HINT_W'($urandom_range(0, 65535));
            else
               h = bsa_pkg::HINT_W'($urandom_range(0, 2 * eff + 1));
            issue(c, b, h, 1'b0, none);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_bitmap_slot_allocator passed");
      else
         $display("tb_bitmap_slot_allocator failed");
      $finish;
   end

endmodule
